@@ design/ntc_pkg.sv @@
package ntc_pkg;

	localparam int DEF_ENTRIES = 34;
	localparam int TAB_SLOTS = 64;
	localparam int TAB_AW = 6;
	localparam int TAB_W = 11;
	localparam int QUO_W = 9;
	localparam int DIVD_W = 20;
	localparam int TEMP_W = 15;

	localparam logic [15:0] STEP_CD = 16'd500;
	localparam logic [15:0] TEMP_OFS = 16'd4000;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN_CD = -15'sd4000;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX_CD = 15'sd12500;

	function automatic logic [TAB_W-1:0] tab_value(input logic [TAB_AW-1:0] idx);
		logic [TAB_W-1:0] v;
		case (idx)
			6'd0: v = 11'd1996;
			6'd1: v = 11'd1978;
			6'd2: v = 11'd1952;
			6'd3: v = 11'd1920;
			6'd4: v = 11'd1878;
			6'd5: v = 11'd1826;
			6'd6: v = 11'd1762;
			6'd7: v = 11'd1684;
			6'd8: v = 11'd1594;
			6'd9: v = 11'd1494;
			6'd10: v = 11'd1384;
			6'd11: v = 11'd1266;
			6'd12: v = 11'd1144;
			6'd13: v = 11'd1022;
			6'd14: v = 11'd903;
			6'd15: v = 11'd791;
			6'd16: v = 11'd687;
			6'd17: v = 11'd593;
			6'd18: v = 11'd509;
			6'd19: v = 11'd435;
			6'd20: v = 11'd370;
			6'd21: v = 11'd315;
			6'd22: v = 11'd268;
			6'd23: v = 11'd229;
			6'd24: v = 11'd195;
			6'd25: v = 11'd166;
			6'd26: v = 11'd142;
			6'd27: v = 11'd121;
			6'd28: v = 11'd104;
			6'd29: v = 11'd90;
			6'd30: v = 11'd77;
			6'd31: v = 11'd67;
			6'd32: v = 11'd58;
			6'd33: v = 11'd50;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ design/ntc_ram.sv @@
module ntc_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/ntc_div.sv @@
module ntc_div import ntc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [TAB_W-1:0]  divisor,
	output logic [QUO_W-1:0]  quo,
	output logic              done
);

	localparam int CNT_W = $clog2(QUO_W);

	logic [DIVD_W-1:0] rem_q;
	logic [TAB_W-1:0]  div_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DIVD_W-1:0] shifted;
	logic              take;

	assign shifted = DIVD_W'(div_q) << cnt_q;
	assign take = (div_q != '0) && (rem_q >= shifted);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(QUO_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			div_q <= divisor;
			quo_q <= '0;
		end else if (run_q && take) begin
			rem_q <= rem_q - shifted;
			quo_q[cnt_q] <= 1'b1;
		end
	end

	assign quo = quo_q;
	assign done = done_q;

endmodule

@@ design/ntc_table_linearizer_core.sv @@
// done is raised from the CHK_HI state for a code above the first entry, from CHK_LO for one below the last,
// otherwise after a binary search over N = min(TABLE_ENTRIES-1, 34) entries and the divide,
// with one table read per search probe on the single ram port and a 9-step serial divide
// throughput: one item at a time, busy falls as done rises so the next item can be taken then
// reset: the table ram is loaded from the constant table into all 64 slots with busy high
// done marks temp_centideg for one cycle, the receiver cannot stall
module ntc_table_linearizer_core import ntc_pkg::*; #(
	parameter int TABLE_ENTRIES = 34,
	parameter int ADC_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ADC_BITS-1:0]        adc_code,
	output logic                       busy,
	output logic                       done,
	output logic signed [TEMP_W-1:0]   temp_centideg
);

	localparam int SEARCH_N = (TABLE_ENTRIES - 1 < DEF_ENTRIES) ? TABLE_ENTRIES - 1 : DEF_ENTRIES;
	localparam bit ZERO_TAIL = TABLE_ENTRIES > DEF_ENTRIES + 1;
	localparam logic [TAB_AW-1:0] LAST_IDX = TAB_AW'(TABLE_ENTRIES - 1);
	localparam logic [TAB_AW-1:0] TOP_IDX = TAB_AW'(SEARCH_N - 1);
	localparam logic [TAB_AW-1:0] ZERO_SEG = TAB_AW'(TABLE_ENTRIES - 2);
	localparam logic [TAB_AW-1:0] FILL_END = TAB_AW'(TAB_SLOTS - 1);

	typedef enum logic [8:0] {
		ST_FILL   = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_CHK_HI = 9'b000000100,
		ST_CHK_LO = 9'b000001000,
		ST_PROBE  = 9'b000010000,
		ST_CMP    = 9'b000100000,
		ST_RD_HI  = 9'b001000000,
		ST_RD_LO  = 9'b010000000,
		ST_DIV    = 9'b100000000
	} state_t;

	state_t               state_q;
	logic [TAB_AW-1:0]    fill_q;
	logic [ADC_BITS-1:0]  code_q;
	logic [TAB_AW-1:0]    lo_q;
	logic [TAB_AW-1:0]    hi_q;
	logic [TAB_AW-1:0]    mid_q;
	logic [TAB_AW-1:0]    seg_q;
	logic [TAB_W-1:0]     hcode_q;
	logic                 done_q;
	logic signed [TEMP_W-1:0] temp_q;

	logic [TAB_AW-1:0]    rd_addr;
	logic [TAB_W-1:0]     rd_data;
	logic [ADC_BITS-1:0]  rd_ext;
	logic [TAB_AW:0]      mid_sum;
	logic [TAB_AW-1:0]    mid;
	logic [TAB_W-1:0]     diff;
	logic [TAB_W-1:0]     span;
	logic [DIVD_W-1:0]    dividend;
	logic                 div_start;
	logic [QUO_W-1:0]     quo;
	logic                 div_done;
	logic [15:0]          sum;

	ntc_ram #(
		.WIDTH(TAB_W),
		.DEPTH(TAB_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (state_q == ST_FILL),
		.waddr (fill_q),
		.wdata (tab_value(fill_q)),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	ntc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (span),
		.quo      (quo),
		.done     (div_done)
	);

	assign rd_ext = ADC_BITS'(rd_data);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;
	assign mid = mid_sum[TAB_AW:1];
	assign diff = hcode_q - code_q[TAB_W-1:0];
	assign span = (hcode_q > rd_data) ? hcode_q - rd_data : '0;
	assign dividend = DIVD_W'(diff) * DIVD_W'(STEP_CD);
	assign div_start = state_q == ST_RD_LO;
	assign sum = 16'(quo) + 16'(seg_q) * STEP_CD - TEMP_OFS;

	always_comb begin
		case (state_q)
			ST_IDLE:   rd_addr = '0;
			ST_CHK_HI: rd_addr = LAST_IDX;
			ST_CHK_LO: rd_addr = ZERO_SEG;
			ST_PROBE:  rd_addr = (lo_q == hi_q) ? lo_q : mid;
			ST_RD_HI:  rd_addr = seg_q + 1'b1;
			default:   rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == FILL_END) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHK_HI;
					end
				end
				ST_CHK_HI: begin
					if (code_q > rd_ext) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_CHK_LO;
					end
				end
				ST_CHK_LO: begin
					if (code_q < rd_ext) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else if (ZERO_TAIL && code_q == '0) begin
						state_q <= ST_RD_HI;
					end else begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (lo_q == hi_q) begin
						state_q <= ST_RD_HI;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: state_q <= ST_PROBE;
				ST_RD_HI: state_q <= ST_RD_LO;
				ST_RD_LO: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				code_q <= adc_code;
			end
			ST_CHK_HI: begin
				temp_q <= TEMP_MIN_CD;
			end
			ST_CHK_LO: begin
				temp_q <= TEMP_MAX_CD;
				lo_q <= '0;
				hi_q <= TOP_IDX;
				seg_q <= ZERO_SEG;
			end
			ST_PROBE: begin
				mid_q <= mid;
				if (lo_q == hi_q) begin
					seg_q <= lo_q;
				end
			end
			ST_CMP: begin
				if (rd_ext >= code_q) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q - 1'b1;
				end
			end
			ST_RD_HI: begin
				hcode_q <= rd_data;
			end
			ST_DIV: begin
				temp_q <= sum[TEMP_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;
	assign temp_centideg = temp_q;

endmodule
